// ===== rtl/core/mcpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcpg_pkg;

   localparam int unsigned CoordWidth  = 12;
   localparam int unsigned RadiusWidth = 11;
   localparam int unsigned OriginWidth = 11;
   localparam int unsigned PixelWidth  = 14;
   localparam int unsigned DecWidth    = 16;
   localparam int unsigned CsrIdxWidth = 8;
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 32;
   localparam int unsigned PointCount   = 8;

   localparam logic [OriginWidth-1:0] OriginXReset = 11'd320;
   localparam logic [OriginWidth-1:0] OriginYReset = 11'd240;

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_CENTRE = 2'd0,
      KIND_POINT  = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   localparam logic [CsrIdxWidth-1:0] CSR_ORIGIN_X = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ORIGIN_Y = 8'd1;

   // One unit of work for the back end: the points of one octant step,
   // the centre point of a new circle, or the finished marker.
   typedef struct packed {
      kind_type                      kind;
      logic signed [CoordWidth-1:0]  cx;
      logic signed [CoordWidth-1:0]  cy;
      logic        [CoordWidth-1:0]  x;
      logic        [CoordWidth-1:0]  y;
   } job_type;

endpackage : mcpg_pkg

`default_nettype wire

// ===== rtl/core/mcpg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcpg_front (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_tvalid,
   output logic                                     req_tready,
   input  wire                                      req_tuser,
   input  wire  [mcpg_pkg::ReqDataWidth-1:0]        req_tdata,
   output logic                                     push,
   output mcpg_pkg::job_type                        push_job,
   input  wire                                      push_ready
);
   import mcpg_pkg::*;

   logic [CoordWidth-1:0] step_x_ff, step_x_in;
   logic [CoordWidth-1:0] step_y_ff, step_y_in;
   logic [DecWidth-1:0]   decision_ff, decision_in;
   logic [CoordWidth-1:0] held_cx_ff, held_cx_in;
   logic [CoordWidth-1:0] held_cy_ff, held_cy_in;

   logic                   accept;
   logic [CoordWidth-1:0]  center_x;
   logic [CoordWidth-1:0]  center_y;
   logic [RadiusWidth-1:0] radius;
   logic [DecWidth-1:0]    x_wide;
   logic [DecWidth-1:0]    y_wide;
   logic [DecWidth-1:0]    diff_wide;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;
   assign center_x   = req_tdata[11:0];
   assign center_y   = req_tdata[23:12];
   assign radius     = req_tdata[34:24];
   assign x_wide     = {{(DecWidth-CoordWidth){1'b0}}, step_x_ff};
   assign y_wide     = {{(DecWidth-CoordWidth){1'b0}}, step_y_ff};
   assign diff_wide  = x_wide - y_wide;

   always_comb begin
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      decision_in = decision_ff;
      held_cx_in  = held_cx_ff;
      held_cy_in  = held_cy_ff;
      push_job.kind = KIND_DONE;
      push_job.cx   = held_cx_ff;
      push_job.cy   = held_cy_ff;
      push_job.x    = '0;
      push_job.y    = '0;
      if (op_type'(req_tuser) == OP_START) begin
         held_cx_in    = center_x;
         held_cy_in    = center_y;
         step_x_in     = '0;
         step_y_in     = {1'b0, radius};
         decision_in   = 16'd3 - {4'b0000, radius, 1'b0};
         push_job.kind = KIND_CENTRE;
         push_job.cx   = center_x;
         push_job.cy   = center_y;
      end else if (step_x_ff < step_y_ff) begin
         step_x_in = step_x_ff + 12'd1;
         if (decision_ff[DecWidth-1]) begin
            decision_in = decision_ff + {x_wide[DecWidth-3:0], 2'b00} + 16'd6;
         end else begin
            decision_in = decision_ff + {diff_wide[DecWidth-3:0], 2'b00} + 16'd10;
            step_y_in   = step_y_ff - 12'd1;
         end
         push_job.kind = KIND_POINT;
         push_job.x    = step_x_in;
         push_job.y    = step_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff   <= '0;
         step_y_ff   <= '0;
         decision_ff <= '0;
         held_cx_ff  <= '0;
         held_cy_ff  <= '0;
      end else if (accept) begin
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         decision_ff <= decision_in;
         held_cx_ff  <= held_cx_in;
         held_cy_ff  <= held_cy_in;
      end
   end

   a_start_clears_x: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == OP_START |=> step_x_ff == '0)
      else $error("Step x not cleared by a start transaction.");

   a_step_advances_x: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == OP_STEP && push_job.kind == KIND_POINT
      |=> step_x_ff == $past(step_x_ff) + 12'd1)
      else $error("Step x did not advance on a point step.");

endmodule : mcpg_front

`default_nettype wire

// ===== rtl/core/mcpg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcpg_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  mcpg_pkg::job_type   push_job,
   output logic                push_ready,
   input  wire                 pop,
   output mcpg_pkg::job_type   head_job,
   output logic                head_valid
);
   import mcpg_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   job_type               slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = count_ff != FullCnt;
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("Queue occupancy exceeds its depth.");

endmodule : mcpg_queue

`default_nettype wire

// ===== rtl/core/mcpg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcpg_back (
   input  wire                                    clock,
   input  wire                                    reset,
   input  mcpg_pkg::job_type                      head_job,
   input  wire                                    head_valid,
   output logic                                   pop,
   input  wire  [mcpg_pkg::OriginWidth-1:0]       origin_x,
   input  wire  [mcpg_pkg::OriginWidth-1:0]       origin_y,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [1:0]                             rsp_tuser,
   output logic                                   rsp_tlast,
   output logic [mcpg_pkg::RspDataWidth-1:0]      rsp_tdata
);
   import mcpg_pkg::*;

   logic [2:0]            idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff;
   logic                  rsp_last_ff;
   logic [PixelWidth-1:0] rsp_px_ff;
   logic [PixelWidth-1:0] rsp_py_ff;

   logic                  emit;
   logic                  is_last;
   logic [CoordWidth-1:0] term_a;
   logic [CoordWidth-1:0] term_b;
   logic [PixelWidth-1:0] off_a;
   logic [PixelWidth-1:0] off_b;
   logic [PixelWidth-1:0] px;
   logic [PixelWidth-1:0] py;

   assign emit    = head_valid && (!rsp_valid_ff || rsp_tready);
   assign is_last = (head_job.kind != KIND_POINT) || (idx_ff == 3'(PointCount - 1));
   assign pop     = emit && is_last;

   // The upper four points swap the roles of x and y; bit 1 of the index
   // mirrors the x term and bit 0 the y term.
   always_comb begin
      term_a = idx_ff[2] ? head_job.y : head_job.x;
      term_b = idx_ff[2] ? head_job.x : head_job.y;
      off_a  = {2'b00, term_a};
      off_b  = {2'b00, term_b};
      if (idx_ff[1]) begin
         off_a = -off_a;
      end
      if (idx_ff[0]) begin
         off_b = -off_b;
      end
      px = {{2{head_job.cx[CoordWidth-1]}}, head_job.cx} + off_a + {3'b000, origin_x};
      py = {{2{head_job.cy[CoordWidth-1]}}, head_job.cy} + off_b + {3'b000, origin_y};
      if (head_job.kind == KIND_DONE) begin
         px = '0;
         py = '0;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         idx_in       = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= head_job.kind;
         rsp_last_ff <= is_last;
         rsp_px_ff   <= px;
         rsp_py_ff   <= py;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RspDataWidth-2*PixelWidth){1'b0}}, rsp_py_ff, rsp_px_ff};

   a_index_needs_job: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 3'd0 |-> head_valid && head_job.kind == KIND_POINT)
      else $error("Point index is mid-job without a point job at the head.");

endmodule : mcpg_back

`default_nettype wire

// ===== rtl/core/midpoint_circle_point_generator_top.sv =====
// A request's job is held in a queue slot and its result then in the single output
// register before it is offered. A start or a finished step yields one result; a point
// step yields eight mirrored points, emitted one per cycle unless the output stalls.
// The front end runs ahead of the point emitter by up to QUEUE_DEPTH requests.
// Reset is synchronous and active high; it clears the circle state and the queue and
// returns the origin registers to 320 and 240.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_point_generator_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire                                    req_tuser,   // operation
   input  wire  [mcpg_pkg::ReqDataWidth-1:0]      req_tdata,   // center_x, center_y, radius
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [1:0]                             rsp_tuser,   // kind
   output logic                                   rsp_tlast,
   output logic [mcpg_pkg::RspDataWidth-1:0]      rsp_tdata,   // pixel_x, pixel_y
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [mcpg_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire  [mcpg_pkg::OriginWidth-1:0]       csr_data
);
   import mcpg_pkg::*;

   logic [OriginWidth-1:0] origin_x_ff;
   logic [OriginWidth-1:0] origin_y_ff;

   logic    push;
   job_type push_job;
   logic    push_ready;
   logic    pop;
   job_type head_job;
   logic    head_valid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= OriginXReset;
         origin_y_ff <= OriginYReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_data;
            CSR_ORIGIN_Y: origin_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mcpg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   mcpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid)
   );

   mcpg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (pop),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

endmodule : midpoint_circle_point_generator_top

`default_nettype wire

// ===== tb/sv/midpoint_circle_checker.sv =====
`timescale 1ns / 1ps

module midpoint_circle_checker (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   input  wire                                  req_tready,
   input  wire                                  req_tuser,
   input  wire  [mcpg_pkg::ReqDataWidth-1:0]    req_tdata,
   input  wire                                  rsp_tvalid,
   input  wire                                  rsp_tready,
   input  wire  [1:0]                           rsp_tuser,
   input  wire                                  rsp_tlast,
   input  wire  [mcpg_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  wire                                  csr_valid,
   input  wire                                  csr_ready,
   input  wire  [mcpg_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire  [mcpg_pkg::OriginWidth-1:0]     csr_data,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   centre_seen,
   output int                                   point_seen,
   output int                                   done_seen
);
   import mcpg_pkg::*;

   typedef struct packed {
      kind_type                kind;
      logic [PixelWidth-1:0]   px;
      logic [PixelWidth-1:0]   py;
      logic                    last;
   } pixel_result_type;

   pixel_result_type expected_pixels[$];

   logic [OriginWidth-1:0] origin_x;
   logic [OriginWidth-1:0] origin_y;
   logic [CoordWidth-1:0]  oct_x;
   logic [CoordWidth-1:0]  oct_y;
   logic [DecWidth-1:0]    decision;
   logic [CoordWidth-1:0]  centre_x;
   logic [CoordWidth-1:0]  centre_y;

   function automatic void push_pixel(input kind_type k, input int px, input int py,
                                      input logic last);
      pixel_result_type e;
      e.kind = k;
      e.px   = px[PixelWidth-1:0];
      e.py   = py[PixelWidth-1:0];
      e.last = last;
      expected_pixels.push_back(e);
   endfunction

   task automatic trace_circle(input op_type op, input logic [CoordWidth-1:0] cx_in,
                               input logic [CoordWidth-1:0] cy_in,
                               input logic [RadiusWidth-1:0] r_in);
      int x;
      int y;
      int s;
      int cx;
      int cy;
      int ox;
      int oy;
      int dx[8];
      int dy[8];
      ox = int'(origin_x);
      oy = int'(origin_y);
      if (op == OP_START) begin
         centre_x = cx_in;
         centre_y = cy_in;
         oct_x    = '0;
         oct_y    = {1'b0, r_in};
         s        = 3 - 2 * int'(r_in);
         decision = s[DecWidth-1:0];
         cx       = int'($signed(cx_in));
         cy       = int'($signed(cy_in));
         push_pixel(KIND_CENTRE, cx + ox, cy + oy, 1'b1);
      end else if (oct_x >= oct_y) begin
         push_pixel(KIND_DONE, 0, 0, 1'b1);
      end else begin
         x  = int'(oct_x);
         y  = int'(oct_y);
         s  = int'($signed(decision));
         cx = int'($signed(centre_x));
         cy = int'($signed(centre_y));
         if (s < 0) begin
            s = s + 4 * x + 6;
            x = x + 1;
         end else begin
            s = s + 4 * (x - y) + 10;
            x = x + 1;
            y = y - 1;
         end
         decision = s[DecWidth-1:0];
         oct_x    = x[CoordWidth-1:0];
         oct_y    = y[CoordWidth-1:0];
         dx = '{x, x, -x, -x, y, y, -y, -y};
         dy = '{y, -y, y, -y, x, -x, x, -x};
         for (int i = 0; i < PointCount; i++) begin
            push_pixel(KIND_POINT, cx + dx[i] + ox, cy + dy[i] + oy, i == PointCount - 1);
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      if (reset) begin
         origin_x = OriginXReset;
         origin_y = OriginYReset;
         oct_x    = '0;
         oct_y    = '0;
         decision = '0;
         centre_x = '0;
         centre_y = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = kind_type'(rsp_tuser);
            got.px   = rsp_tdata[PixelWidth-1:0];
            got.py   = rsp_tdata[2*PixelWidth-1:PixelWidth];
            got.last = rsp_tlast;
            case (got.kind)
               KIND_CENTRE: centre_seen++;
               KIND_POINT:  point_seen++;
               default:     done_seen++;
            endcase
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Unexpected result transaction: kind %0d x %0d y %0d last %0d",
                           got.kind, $signed(got.px), $signed(got.py), got.last);
               end
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display({"Result mismatch: expected kind %0d x %0d y %0d last %0d,",
                               " got kind %0d x %0d y %0d last %0d"},
                              want.kind, $signed(want.px), $signed(want.py), want.last,
                              got.kind, $signed(got.px), $signed(got.py), got.last);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ORIGIN_X) begin
               origin_x = csr_data;
            end else if (csr_index == CSR_ORIGIN_Y) begin
               origin_y = csr_data;
            end
         end
         if (req_tvalid && req_tready) begin
            trace_circle(op_type'(req_tuser), req_tdata[CoordWidth-1:0],
                         req_tdata[2*CoordWidth-1:CoordWidth],
                         req_tdata[2*CoordWidth+RadiusWidth-1:2*CoordWidth]);
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import mcpg_pkg::*;

   localparam int unsigned CycleLimit = 300000;
   localparam int unsigned HoldCycles = 400;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tuser  = 1'b0;
   logic [ReqDataWidth-1:0]  req_tdata  = '0;
   logic                     rsp_tready = 1'b0;
   logic                     csr_valid  = 1'b0;
   logic [CsrIdxWidth-1:0]   csr_index  = '0;
   logic [OriginWidth-1:0]   csr_data   = '0;
   wire                      req_tready;
   wire                      rsp_tvalid;
   wire  [1:0]               rsp_tuser;
   wire                      rsp_tlast;
   wire  [RspDataWidth-1:0]  rsp_tdata;
   wire                      csr_ready;

   int          fail_count;
   int          pending;
   int          centre_seen;
   int          point_seen;
   int          done_seen;
   int unsigned idle_pct      = 0;
   int unsigned stall_pct     = 0;
   int unsigned requests_sent = 0;
   int unsigned circles_begun = 0;
   int unsigned cycle_count   = 0;
   int unsigned hold_left     = 0;
   bit          hold_trigger  = 1'b0;
   bit          hold_seen     = 1'b0;

   midpoint_circle_point_generator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   midpoint_circle_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .centre_seen (centre_seen),
      .point_seen  (point_seen),
      .done_seen   (done_seen)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The output side stalls at random, except during a requested hold-off, when it refuses
   // every transaction for a fixed stretch so that the block backs up into its input.
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_left  <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_req(input op_type op, input logic [CoordWidth-1:0] cx,
                           input logic [CoordWidth-1:0] cy,
                           input logic [RadiusWidth-1:0] r);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(ReqDataWidth - 2*CoordWidth - RadiusWidth){1'b0}}, r, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (op == OP_START) circles_begun++;
      @(negedge clock);
   endtask

   task automatic step_n(input int unsigned n);
      for (int unsigned k = 0; k < n; k++) begin
         send_req(OP_STEP, CoordWidth'($urandom_range(0, 4095)),
                  CoordWidth'($urandom_range(0, 4095)),
                  RadiusWidth'($urandom_range(0, 2047)));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_origin(input logic [OriginWidth-1:0] ox,
                             input logic [OriginWidth-1:0] oy);
      csr_valid <= 1'b1;
      csr_index <= CSR_ORIGIN_X;
      csr_data  <= ox;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_ORIGIN_Y;
      csr_data  <= oy;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly complete circles with random centres and small radii, now and then a large
   // radius cut short, and some stray steps and lone starts.
   task automatic draw_random(input int unsigned count);
      int unsigned sent;
      int unsigned r;
      int unsigned steps;
      int unsigned pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            if ($urandom_range(0, 9) == 0) begin
               r     = $urandom_range(0, 2047);
               steps = $urandom_range(1, 6);
            end else begin
               r     = $urandom_range(0, 14);
               steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, r) : r + 1;
            end
            send_req(OP_START, CoordWidth'($urandom_range(0, 4095)),
                     CoordWidth'($urandom_range(0, 4095)), RadiusWidth'(r));
            step_n(steps);
            sent += steps + 1;
         end else if (pick < 90) begin
            step_n(1);
            sent++;
         end else begin
            send_req(OP_START, CoordWidth'($urandom_range(0, 4095)),
                     CoordWidth'($urandom_range(0, 4095)),
                     RadiusWidth'($urandom_range(0, 2047)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      step_n(1);
      send_req(OP_START, 12'h800, 12'h800, 11'd0);
      step_n(2);
      send_req(OP_START, 12'h7FF, 12'h7FF, 11'd2047);
      step_n(3);
      send_req(OP_START, 12'h800, 12'h7FF, 11'd1);
      step_n(2);
      send_req(OP_START, 12'h000, 12'h000, 11'd5);
      step_n(6);
      send_req(OP_START, 12'h555, 12'hAAA, 11'h555);
      step_n(1);
      draw_random(35);

      drain();
      set_origin(11'd2047, 11'd0);
      idle_pct = 70;
      send_req(OP_START, 12'h7FF, 12'h800, 11'd2047);
      step_n(2);
      draw_random(55);

      drain();
      set_origin(11'd0, 11'd2047);
      idle_pct  = 0;
      stall_pct = 70;
      send_req(OP_START, 12'h800, 12'h7FF, 11'd2047);
      step_n(2);
      draw_random(55);

      drain();
      set_origin(OriginWidth'($urandom_range(0, 2047)),
                 OriginWidth'($urandom_range(0, 2047)));
      idle_pct  = 15;
      stall_pct = 15;
      draw_random(55);

      drain();
      set_origin(OriginWidth'($urandom_range(0, 2047)),
                 OriginWidth'($urandom_range(0, 2047)));
      idle_pct     = 0;
      stall_pct    = 0;
      hold_trigger = ~hold_trigger;
      draw_random(40);

      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d request transactions covering %0d circles under five origin settings,",
               requests_sent, circles_begun);
      $display("checking %0d centre points, %0d circle points and %0d finished markers.",
               centre_seen, point_seen, done_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== midpoint_circle_point_generator_top.f =====
rtl/core/mcpg_pkg.sv
rtl/core/mcpg_front.sv
rtl/core/mcpg_queue.sv
rtl/core/mcpg_back.sv
rtl/core/midpoint_circle_point_generator_top.sv
tb/sv/midpoint_circle_checker.sv
tb/sv/tb.sv
